@@ hdl/apos_pkg.sv @@
// Shared types and constants for the ADC polling over-current sequencer.
// Used by apos_cfg_regs, apos_event_plan, apos_emitter and the top level.
// No dependencies.
package apos_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int CHAN_MAX_W       = 3;

  // bytes expected from every converter read
  localparam logic [4:0] READ_BYTES = 5'd2;

  // controller TX FIFO word flags
  localparam logic [9:0] W_START = 10'h100;
  localparam logic [9:0] W_STOP  = 10'h200;

  // configuration reset values
  localparam logic [11:0] THRESHOLD_RST  = 12'd1500;
  localparam logic [6:0]  BUS_ADDR_RST   = 7'd72;
  localparam logic [7:0]  CONF_PTR_RST   = 8'd1;
  localparam logic [7:0]  CONV_PTR_RST   = 8'd0;
  localparam logic [7:0]  CONF_HIGH_RST  = 8'd193;
  localparam logic [7:0]  CONF_LOW_RST   = 8'd131;
  localparam logic [7:0]  READY_MASK_RST = 8'd128;

  typedef enum logic [2:0] {
    ACT_BEGIN     = 3'd0,
    ACT_TX        = 3'd1,
    ACT_POWER_OFF = 3'd2,
    ACT_REINIT    = 3'd3,
    ACT_ACK       = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    PH_CONF_WRITE  = 3'd0,
    PH_POLL_REQ    = 3'd1,
    PH_POLL_CHECK  = 3'd2,
    PH_RESULT_REQ  = 3'd3,
    PH_RESULT_TAKE = 3'd4
  } phase_t;

  // command burst that forms the body of an event
  typedef enum logic [1:0] {
    BODY_CONF = 2'd0,
    BODY_POLL = 2'd1,
    BODY_READ = 2'd2
  } body_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_BUS_ADDR   = 3'd1,
    REG_CONF_PTR   = 3'd2,
    REG_CONV_PTR   = 3'd3,
    REG_CONF_HIGH  = 3'd4,
    REG_CONF_LOW   = 3'd5,
    REG_READY_MASK = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] threshold;
    logic [6:0]  bus_addr;
    logic [7:0]  conf_ptr;
    logic [7:0]  conv_ptr;
    logic [7:0]  conf_high;
    logic [7:0]  conf_low;
    logic [7:0]  ready_mask;
  } cfg_t;

  // one event's result list: optional head item, a command burst, then the ack
  typedef struct packed {
    logic                  head_vld;
    action_t               head_act;
    logic [CHAN_MAX_W-1:0] head_chan;
    logic [11:0]           head_reading;
    body_t                 body;
    logic [CHAN_MAX_W-1:0] body_chan;
    logic [11:0]           body_reading;
  } plan_t;

endpackage

@@ hdl/apos_cfg_regs.sv @@
// APB-style configuration registers of the over-current sequencer.
// Depends on apos_pkg (cfg_t, reg_idx_t, reset values).
module apos_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output apos_pkg::cfg_t   cfg
);

  logic               wr_en;
  apos_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = apos_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= apos_pkg::THRESHOLD_RST;
      cfg.bus_addr   <= apos_pkg::BUS_ADDR_RST;
      cfg.conf_ptr   <= apos_pkg::CONF_PTR_RST;
      cfg.conv_ptr   <= apos_pkg::CONV_PTR_RST;
      cfg.conf_high  <= apos_pkg::CONF_HIGH_RST;
      cfg.conf_low   <= apos_pkg::CONF_LOW_RST;
      cfg.ready_mask <= apos_pkg::READY_MASK_RST;
    end else if (wr_en) begin
      unique case (idx)
        apos_pkg::REG_THRESHOLD:  cfg.threshold  <= pwdata[11:0];
        apos_pkg::REG_BUS_ADDR:   cfg.bus_addr   <= pwdata[6:0];
        apos_pkg::REG_CONF_PTR:   cfg.conf_ptr   <= pwdata[7:0];
        apos_pkg::REG_CONV_PTR:   cfg.conv_ptr   <= pwdata[7:0];
        apos_pkg::REG_CONF_HIGH:  cfg.conf_high  <= pwdata[7:0];
        apos_pkg::REG_CONF_LOW:   cfg.conf_low   <= pwdata[7:0];
        apos_pkg::REG_READY_MASK: cfg.ready_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      apos_pkg::REG_THRESHOLD:  prdata = {20'd0, cfg.threshold};
      apos_pkg::REG_BUS_ADDR:   prdata = {25'd0, cfg.bus_addr};
      apos_pkg::REG_CONF_PTR:   prdata = {24'd0, cfg.conf_ptr};
      apos_pkg::REG_CONV_PTR:   prdata = {24'd0, cfg.conv_ptr};
      apos_pkg::REG_CONF_HIGH:  prdata = {24'd0, cfg.conf_high};
      apos_pkg::REG_CONF_LOW:   prdata = {24'd0, cfg.conf_low};
      apos_pkg::REG_READY_MASK: prdata = {24'd0, cfg.ready_mask};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/apos_event_plan.sv @@
// Input register, phase state machine and per-channel reading store.
// Turns one interrupt event into a plan_t for the emitter.
// Depends on apos_pkg.
module apos_event_plan #(
  parameter int NUM_CHANNELS = apos_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                tx_fifo_empty,
  input  logic [4:0]          rx_byte_count,
  input  logic [7:0]          rx_first_byte,
  input  logic [7:0]          rx_second_byte,
  input  logic                take,
  input  apos_pkg::cfg_t      cfg,
  output apos_pkg::plan_t     plan,
  output logic                plan_vld,
  output apos_pkg::phase_t    phase
);

  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CHW-1:0] LAST_CHAN = CHW'(NUM_CHANNELS - 1);

  logic                 hold;
  logic                 fifo_empty_q;
  logic [4:0]           cnt_q;
  logic [7:0]           b0_q;
  logic [7:0]           b1_q;

  apos_pkg::phase_t     phase_next;
  apos_pkg::phase_t     eff_phase;
  logic [CHW-1:0]       chan;
  logic [CHW-1:0]       chan_inc;
  logic [CHW-1:0]       rd_addr;
  logic [11:0]          store [NUM_CHANNELS];
  logic [11:0]          rd_data;

  logic                 count_ok;
  logic                 ready_hit;
  logic [11:0]          new_reading;
  logic                 advance;
  logic                 head_vld;
  apos_pkg::action_t    head_act;
  apos_pkg::body_t      body;

  // input register: refill as soon as the held item goes to the emitter
  assign in_ready = !hold || take;
  assign plan_vld = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (in_ready) begin
      hold <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fifo_empty_q <= tx_fifo_empty;
      cnt_q        <= rx_byte_count;
      b0_q         <= rx_first_byte;
      b1_q         <= rx_second_byte;
    end
  end

  // state register, channel pointer and reading store
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= apos_pkg::PH_CONF_WRITE;
      chan  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store[i] <= '0;
      end
    end else if (take) begin
      phase <= phase_next;
      if (advance) begin
        store[chan] <= new_reading;
        chan        <= chan_inc;
      end
    end
  end

  // next phase and event shape
  always_comb begin
    count_ok    = cnt_q == apos_pkg::READ_BYTES;
    ready_hit   = |(b0_q & cfg.ready_mask);
    new_reading = {b0_q, b1_q[7:4]};
    eff_phase   = fifo_empty_q ? phase : apos_pkg::PH_CONF_WRITE;
    head_vld    = !fifo_empty_q;
    head_act    = apos_pkg::ACT_REINIT;
    body        = apos_pkg::BODY_CONF;
    advance     = 1'b0;
    phase_next  = apos_pkg::PH_POLL_REQ;
    unique case (eff_phase)
      apos_pkg::PH_POLL_REQ: begin
        body       = apos_pkg::BODY_POLL;
        phase_next = apos_pkg::PH_POLL_CHECK;
      end
      apos_pkg::PH_POLL_CHECK: begin
        if (!count_ok) begin
          head_vld = 1'b1;
        end else if (ready_hit) begin
          body       = apos_pkg::BODY_READ;
          phase_next = apos_pkg::PH_RESULT_TAKE;
        end else begin
          body       = apos_pkg::BODY_POLL;
          phase_next = apos_pkg::PH_POLL_CHECK;
        end
      end
      apos_pkg::PH_RESULT_REQ: begin
        body       = apos_pkg::BODY_READ;
        phase_next = apos_pkg::PH_RESULT_TAKE;
      end
      apos_pkg::PH_RESULT_TAKE: begin
        if (!count_ok) begin
          head_vld = 1'b1;
        end else begin
          advance  = 1'b1;
          head_vld = new_reading > cfg.threshold;
          head_act = apos_pkg::ACT_POWER_OFF;
        end
      end
      default: ;  // conversion write, and the unused codes act the same
    endcase
  end

  // one read port: after an advance only the next channel's reading is needed
  assign chan_inc = (chan == LAST_CHAN) ? '0 : chan + CHW'(1);
  assign rd_addr  = advance ? chan_inc : chan;
  assign rd_data  = store[rd_addr];

  always_comb begin
    plan.head_vld     = head_vld;
    plan.head_act     = head_act;
    plan.head_chan    = apos_pkg::CHAN_MAX_W'(chan);
    plan.head_reading = advance ? new_reading : rd_data;
    plan.body         = body;
    plan.body_chan    = apos_pkg::CHAN_MAX_W'(rd_addr);
    plan.body_reading = rd_data;
  end

endmodule

@@ hdl/apos_emitter.sv @@
// Walks one event plan into the result register, one item per cycle unless stalled.
// Depends on apos_pkg (plan_t, cfg_t, action_t, body_t).
module apos_emitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  apos_pkg::plan_t    plan,
  input  apos_pkg::cfg_t     cfg,
  output logic               can_take,
  output logic               m_tvalid,
  input  logic               m_tready,
  output apos_pkg::action_t  action,
  output logic [9:0]         tx_word,
  output logic [1:0]         channel_number,
  output logic [11:0]        channel_reading,
  output logic               last_of_run
);

  logic                                busy;
  logic [2:0]                          step;
  apos_pkg::plan_t                     pl;

  logic [2:0]                          body_len;
  logic [2:0]                          last_step;
  logic [2:0]                          bidx;
  logic                                adv;
  logic                                push;
  logic                                at_last;

  apos_pkg::action_t                   e_act;
  logic [9:0]                          e_word;
  logic [apos_pkg::CHAN_MAX_W-1:0]     e_chan;
  logic [11:0]                         e_rd;
  logic                                e_last;

  logic [9:0]                          addr_wr;
  logic [9:0]                          addr_rd;
  logic [9:0]                          read_len;
  logic [apos_pkg::CHAN_MAX_W-1:0]     mapped;

  assign body_len  = (pl.body == apos_pkg::BODY_POLL) ? 3'd3 : 3'd5;
  assign last_step = 3'(pl.head_vld) + body_len;
  assign bidx      = step - 3'(pl.head_vld);
  assign adv       = !m_tvalid || m_tready;
  assign push      = busy && adv;
  assign at_last   = step == last_step;
  assign can_take  = !busy || (push && at_last);

  assign addr_wr  = apos_pkg::W_START | {2'b00, cfg.bus_addr, 1'b0};
  assign addr_rd  = apos_pkg::W_START | {2'b00, cfg.bus_addr, 1'b1};
  assign read_len = apos_pkg::W_STOP | 10'(apos_pkg::READ_BYTES);
  assign mapped   = pl.body_chan ^ apos_pkg::CHAN_MAX_W'(1);

  always_comb begin
    e_act  = apos_pkg::ACT_BEGIN;
    e_word = '0;
    e_chan = pl.body_chan;
    e_rd   = pl.body_reading;
    e_last = 1'b0;
    if (pl.head_vld && step == 3'd0) begin
      e_act  = pl.head_act;
      e_chan = pl.head_chan;
      e_rd   = pl.head_reading;
    end else if (at_last) begin
      e_act  = apos_pkg::ACT_ACK;
      e_last = 1'b1;
    end else if (bidx != 3'd0) begin
      e_act = apos_pkg::ACT_TX;
      case (pl.body)
        apos_pkg::BODY_CONF: begin
          case (bidx)
            3'd1:    e_word = addr_wr;
            3'd2:    e_word = {2'b00, cfg.conf_ptr};
            3'd3:    e_word = {2'b00, cfg.conf_high | {1'b0, mapped, 4'b0000}};
            default: e_word = apos_pkg::W_STOP | {2'b00, cfg.conf_low};
          endcase
        end
        apos_pkg::BODY_POLL: begin
          case (bidx)
            3'd1:    e_word = addr_rd;
            default: e_word = read_len;
          endcase
        end
        apos_pkg::BODY_READ: begin
          case (bidx)
            3'd1:    e_word = addr_wr;
            3'd2:    e_word = {2'b00, cfg.conv_ptr};
            3'd3:    e_word = addr_rd;
            default: e_word = read_len;
          endcase
        end
        default: e_word = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        step <= '0;
      end else if (push) begin
        busy <= !at_last;
        step <= step + 3'd1;
      end
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pl <= plan;
    end
    if (push) begin
      action          <= e_act;
      tx_word         <= e_word;
      channel_number  <= e_chan[1:0];
      channel_reading <= e_rd;
      last_of_run     <= e_last;
    end
  end

endmodule

@@ hdl/adc_poll_overcurrent_sequencer_top.sv @@
// Top level of the ADC polling over-current sequencer.
// Instantiates apos_cfg_regs, apos_event_plan and apos_emitter; uses apos_pkg.
//
//   channel   | direction | carries
//   ----------+-----------+--------------------------------------------------
//   s_*       | in        | one controller interrupt event per item
//   m_*       | out       | begin / tx word / power-off / reinit / ack items
//   apb       | in/out    | seven configuration registers at 4*index
//
// Each event yields four to seven result items, one per cycle through the single
// result register unless m_tready stalls it. The input
// register takes the next event while the current one drains; the next plan loads
// in the cycle the previous ack enters the result register. A stalled m_tready
// holds the result register and backs up into s_tready. Synchronous rst returns
// the converter phase to the conversion write, the channel to zero, all stored
// readings to zero and the registers to their defaults; no clearing pass.
module adc_poll_overcurrent_sequencer_top #(
  parameter int NUM_CHANNELS = apos_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // tx_fifo_empty, rx_byte_count[4:0],
                                 // rx_first_byte[7:0], rx_second_byte[7:0], 2'b0
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tx_word[9:0], channel_number[1:0],
                                 // channel_reading[11:0]
  output logic [2:0]  m_tuser,   // action[2:0]
  output logic        m_tlast,   // last_of_run
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  apos_pkg::cfg_t     cfg;
  apos_pkg::plan_t    plan;
  apos_pkg::phase_t   phase;
  apos_pkg::action_t  action;
  logic               plan_vld;
  logic               can_take;
  logic               take;
  logic [9:0]         tx_word;
  logic [1:0]         channel_number;
  logic [11:0]        channel_reading;

  // hand the held event to the emitter when it has room for a new plan
  assign take = plan_vld & can_take;

  apos_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apos_event_plan #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_plan (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .tx_fifo_empty  (s_tdata[0]),
    .rx_byte_count  (s_tdata[5:1]),
    .rx_first_byte  (s_tdata[13:6]),
    .rx_second_byte (s_tdata[21:14]),
    .take           (take),
    .cfg            (cfg),
    .plan           (plan),
    .plan_vld       (plan_vld),
    .phase          (phase)
  );

  apos_emitter u_emit (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .plan            (plan),
    .cfg             (cfg),
    .can_take        (can_take),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .action          (action),
    .tx_word         (tx_word),
    .channel_number  (channel_number),
    .channel_reading (channel_reading),
    .last_of_run     (m_tlast)
  );

  assign m_tuser = action;
  assign m_tdata = {channel_reading, channel_number, tx_word};

`ifndef SYNTH
  // the ack closes every run and nothing else does
  a_last_is_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == apos_pkg::ACT_ACK)))
    else $error("tlast does not match the acknowledge item");

  // only tx word items carry a FIFO word
  a_word_only_tx: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != apos_pkg::ACT_TX)) |-> (m_tdata[9:0] == 10'd0))
    else $error("nonzero tx word on a non-tx item");

  // every event leaves the converter waiting on a poll or a read
  a_phase_after_event: assert property (@(posedge clk) disable iff (rst)
    take |=> (phase == apos_pkg::PH_POLL_REQ || phase == apos_pkg::PH_POLL_CHECK ||
              phase == apos_pkg::PH_RESULT_TAKE))
    else $error("phase left at a code no event ends in");
`endif

endmodule
